// File: design/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types and defaults for the Torben median selector: the command
// and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tms_pkg;

	localparam int SAMPLE_COUNT_DEF = 5;
	localparam int SAMPLE_WIDTH_DEF = 16;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic mm_acc;
		logic mm_first;
		logic pass_clr;
		logic pass_acc;
		logic narrow;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic settled;
	} status_t;

endpackage

`default_nettype wire

// File: design/torben_median_select.sv
// Each group takes from 1 to N+2 counting passes after its min/max scan, N = SAMPLE_COUNT.
// A new group is not accepted until the result of the last one is loaded for output;
//   the single read port of the sample store is scanned one entry a cycle by every
//   min/max and counting pass.
// Reset (arst_n low) empties the group and drops any pending result; store contents persist.
// ----------------------------------------------------------------------------
// torben_median_select
// Collects groups of signed samples and emits the median of each group,
// found by Torben's bound-narrowing method.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module torben_median_select #(
	parameter int SAMPLE_COUNT = tms_pkg::SAMPLE_COUNT_DEF,
	parameter int SAMPLE_WIDTH = tms_pkg::SAMPLE_WIDTH_DEF,
	localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             s_tvalid,
	output logic            s_tready,
	input  wire  [TDW-1:0]  s_tdata,   // [SAMPLE_WIDTH-1:0] sample
	output logic            m_tvalid,
	input  wire             m_tready,
	output logic [TDW-1:0]  m_tdata    // [SAMPLE_WIDTH-1:0] median
);

	localparam int AW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;

	tms_pkg::cmd_t          cmd;
	tms_pkg::status_t       status;
	logic [AW-1:0]          addr;
	logic [SAMPLE_WIDTH-1:0] median;

	tms_ctrl #(
		.SAMPLE_COUNT (SAMPLE_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.addr     (addr),
		.status   (status)
	);

	tms_datapath #(
		.SAMPLE_COUNT (SAMPLE_COUNT),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk     (clk),
		.cmd     (cmd),
		.addr    (addr),
		.wr_data (s_tdata[SAMPLE_WIDTH-1:0]),
		.status  (status),
		.median  (median)
	);

	assign m_tdata = TDW'(median);

endmodule

`default_nettype wire

// File: design/tms_datapath.sv
// ----------------------------------------------------------------------------
// tms_datapath
// Sample store, bound registers, midpoint, per-pass counters and the
// final median selection, all driven by controller commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tms_datapath #(
	parameter int SAMPLE_COUNT = tms_pkg::SAMPLE_COUNT_DEF,
	parameter int SAMPLE_WIDTH = tms_pkg::SAMPLE_WIDTH_DEF,
	localparam int AW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1
) (
	input  wire                     clk,
	input  tms_pkg::cmd_t           cmd,
	input  wire  [AW-1:0]           addr,
	input  wire  [SAMPLE_WIDTH-1:0] wr_data,
	output tms_pkg::status_t        status,
	output logic [SAMPLE_WIDTH-1:0] median
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int CW   = $clog2(SAMPLE_COUNT + 1);
	localparam int HALF = (SAMPLE_COUNT + 1) / 2;

	logic signed [SW-1:0] mem [SAMPLE_COUNT];
	logic signed [SW-1:0] rd_data_s1;

	logic signed [SW-1:0] lo_q, hi_q, guess_q, below_q, above_q, median_q;
	logic        [CW-1:0] less_q, greater_q, equal_q;

	logic signed [SW:0]   sum;
	logic signed [SW:0]   adj;
	logic signed [SW-1:0] mid;
	logic        [CW:0]   less_equal;
	logic signed [SW-1:0] pick;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[addr] <= $signed(wr_data);
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[addr];
		end
	end

	always_comb begin
		sum        = {lo_q[SW-1], lo_q} + {hi_q[SW-1], hi_q};
		adj        = sum + {{SW{1'b0}}, sum[SW]};
		mid        = adj[SW:1];
		less_equal = {1'b0, less_q} + {1'b0, equal_q};
		if (less_q >= CW'(HALF)) begin
			pick = below_q;
		end else if (less_equal >= (CW + 1)'(HALF)) begin
			pick = guess_q;
		end else begin
			pick = above_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mm_acc) begin
			if (cmd.mm_first) begin
				lo_q <= rd_data_s1;
				hi_q <= rd_data_s1;
			end else begin
				if (rd_data_s1 < lo_q) lo_q <= rd_data_s1;
				if (rd_data_s1 > hi_q) hi_q <= rd_data_s1;
			end
		end else if (cmd.narrow) begin
			if (less_q > greater_q) hi_q <= below_q;
			else lo_q <= above_q;
		end

		if (cmd.pass_clr) begin
			guess_q   <= mid;
			below_q   <= lo_q;
			above_q   <= hi_q;
			less_q    <= '0;
			greater_q <= '0;
			equal_q   <= '0;
		end else if (cmd.pass_acc) begin
			if (rd_data_s1 < guess_q) begin
				less_q <= less_q + 1'b1;
				if (rd_data_s1 > below_q) below_q <= rd_data_s1;
			end else if (rd_data_s1 > guess_q) begin
				greater_q <= greater_q + 1'b1;
				if (rd_data_s1 < above_q) above_q <= rd_data_s1;
			end else begin
				equal_q <= equal_q + 1'b1;
			end
		end

		if (cmd.load) begin
			median_q <= pick;
		end
	end

	assign status.settled = (less_q <= CW'(HALF)) && (greater_q <= CW'(HALF));
	assign median         = median_q;

endmodule

`default_nettype wire

// File: design/tms_ctrl.sv
// ----------------------------------------------------------------------------
// tms_ctrl
// Controller: collects a group of samples, sequences the min/max scan and
// the narrowing passes, and holds the result request until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tms_ctrl #(
	parameter int SAMPLE_COUNT = tms_pkg::SAMPLE_COUNT_DEF,
	localparam int AW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  wire               m_tready,
	output tms_pkg::cmd_t     cmd,
	output logic [AW-1:0]     addr,
	input  tms_pkg::status_t  status
);

	localparam int PW  = $clog2(SAMPLE_COUNT + 2);
	localparam int CAP = SAMPLE_COUNT + 1;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_MINMAX,
		ST_MMWAIT,
		ST_PSTART,
		ST_PASS,
		ST_PWAIT,
		ST_NARROW,
		ST_DECIDE
	} state_t;

	state_t        state_q;
	logic [AW-1:0] fill_q;
	logic [AW-1:0] idx_q;
	logic [PW-1:0] pass_q;
	logic          out_valid_q;
	logic          mm_acc_s1, mm_first_s1, pass_acc_s1;

	logic accept;
	logic idx_last;
	logic fill_last;
	logic pass_cap;

	always_comb begin
		s_tready     = (state_q == ST_COLLECT);
		accept       = s_tvalid && s_tready;
		idx_last     = (idx_q == AW'(SAMPLE_COUNT - 1));
		fill_last    = (fill_q == AW'(SAMPLE_COUNT - 1));
		pass_cap     = (pass_q == PW'(CAP));
		cmd.wr_en    = accept;
		cmd.rd_en    = (state_q == ST_MINMAX) || (state_q == ST_PASS);
		cmd.mm_acc   = mm_acc_s1;
		cmd.mm_first = mm_first_s1;
		cmd.pass_clr = (state_q == ST_PSTART);
		cmd.pass_acc = pass_acc_s1;
		cmd.narrow   = (state_q == ST_NARROW) && !status.settled && !pass_cap;
		cmd.load     = (state_q == ST_DECIDE) && (!out_valid_q || m_tready);
		addr         = (state_q == ST_COLLECT) ? fill_q : idx_q;
		m_tvalid     = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			fill_q      <= '0;
			idx_q       <= '0;
			pass_q      <= '0;
			out_valid_q <= 1'b0;
			mm_acc_s1   <= 1'b0;
			mm_first_s1 <= 1'b0;
			pass_acc_s1 <= 1'b0;
		end else begin
			mm_acc_s1   <= (state_q == ST_MINMAX);
			mm_first_s1 <= (state_q == ST_MINMAX) && (idx_q == '0);
			pass_acc_s1 <= (state_q == ST_PASS);

			if (cmd.load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_COLLECT: begin
					if (accept) begin
						if (fill_last) begin
							fill_q  <= '0;
							idx_q   <= '0;
							state_q <= ST_MINMAX;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_MINMAX: begin
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= ST_MMWAIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_MMWAIT: begin
					pass_q  <= '0;
					state_q <= ST_PSTART;
				end
				ST_PSTART: begin
					state_q <= ST_PASS;
				end
				ST_PASS: begin
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= ST_PWAIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_PWAIT: begin
					state_q <= ST_NARROW;
				end
				ST_NARROW: begin
					if (status.settled || pass_cap) begin
						state_q <= ST_DECIDE;
					end else begin
						pass_q  <= pass_q + 1'b1;
						state_q <= ST_PSTART;
					end
				end
				ST_DECIDE: begin
					if (cmd.load) state_q <= ST_COLLECT;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_stall_after_group: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fill_last) |=> !s_tready)
		else $error("input taken after a complete group");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || m_tready))
		else $error("result loaded over an untaken request");

	a_pass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pass_q <= PW'(CAP))
		else $error("pass counter beyond its cap");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= AW'(SAMPLE_COUNT - 1))
		else $error("fill count beyond group size");
`endif

endmodule

`default_nettype wire

// File: verif/tb_torben_median_select.sv
// ----------------------------------------------------------------------------
// tb_torben_median_select
// Streams groups of signed samples into the median selector and checks each
// emitted median against a Torben bound-narrowing predictor kept in a small
// scoreboard. Directed groups cover the range extremes, repeated and equal
// values; random groups mix wide, narrow, extreme-only, equal and repeated content. Both
// stream sides idle at random, and the sender pauses until drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef logic signed [tms_pkg::SAMPLE_WIDTH_DEF-1:0] sample_t;

class median_scoreboard;
	localparam int N = tms_pkg::SAMPLE_COUNT_DEF;

	sample_t group_buf[N];
	int unsigned fill;
	sample_t median_q[$];
	int unsigned errors;

	function new();
		fill = 0;
		errors = 0;
	endfunction

	function sample_t torben_median();
		int lo, hi, guess, below_max, above_min, s;
		int less, greater, equal, half;
		half = (N + 1) / 2;
		lo = group_buf[0];
		hi = group_buf[0];
		guess = lo;
		below_max = lo;
		above_min = hi;
		less = 0;
		greater = 0;
		equal = 0;
		for (int i = 1; i < N; i++) begin
			s = group_buf[i];
			if (s < lo) lo = s;
			if (s > hi) hi = s;
		end
		for (int pass = 0; pass <= N + 1; pass++) begin
			guess = (lo + hi) / 2;
			less = 0;
			greater = 0;
			equal = 0;
			below_max = lo;
			above_min = hi;
			for (int i = 0; i < N; i++) begin
				s = group_buf[i];
				if (s < guess) begin
					less++;
					if (s > below_max) below_max = s;
				end else if (s > guess) begin
					greater++;
					if (s < above_min) above_min = s;
				end else begin
					equal++;
				end
			end
			if (less <= half && greater <= half) break;
			if (less > greater) hi = below_max;
			else lo = above_min;
		end
		if (less >= half) return sample_t'(below_max);
		if (less + equal >= half) return sample_t'(guess);
		return sample_t'(above_min);
	endfunction

	function void note_request(sample_t value);
		group_buf[fill] = value;
		fill++;
		if (fill == N) begin
			fill = 0;
			median_q.push_back(torben_median());
		end
	endfunction

	function void check_median(sample_t got);
		sample_t want;
		if (median_q.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected median %0d", got);
			return;
		end
		want = median_q.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10) $display("median mismatch: expected %0d, got %0d", want, got);
		end
	endfunction

	function int pending();
		return median_q.size();
	endfunction
endclass

module tb_torben_median_select;

	localparam int N = tms_pkg::SAMPLE_COUNT_DEF;
	localparam int W = tms_pkg::SAMPLE_WIDTH_DEF;
	localparam int TDW = ((W + 7) / 8) * 8;
	localparam int RANDOM_GROUPS = 225;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 80;

	localparam sample_t S_MIN = sample_t'(-32768);
	localparam sample_t S_MAX = sample_t'(32767);

	typedef enum int {
		GRP_WIDE,
		GRP_NARROW,
		GRP_EXTREME,
		GRP_EQUAL,
		GRP_REPEAT
	} group_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TDW-1:0] s_tdata = '0;	// [W-1:0] sample
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDW-1:0] m_tdata;	// [W-1:0] median

	median_scoreboard sb = new();
	int unsigned idle_cycles = 0;

	torben_median_select dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	// result side: check on handshake, then pick the next ready level
	int unsigned ready_hold = 0;
	logic ready_level = 1'b0;
	always @(posedge clk) begin
		int unsigned r;
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_median(sample_t'(m_tdata[W-1:0]));
			if (ready_hold == 0) begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					ready_level = 1'b1;
					ready_hold = $urandom_range(1, 8);
				end else if (r < 80) begin
					ready_level = 1'b0;
					ready_hold = $urandom_range(1, 3);
				end else if (r < 93) begin
					ready_level = 1'b1;
					ready_hold = $urandom_range(20, 60);
				end else begin
					ready_level = 1'b0;
					ready_hold = $urandom_range(20, 80);
				end
			end
			ready_hold--;
			m_tready <= ready_level;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic int unsigned next_gap(bit burst);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 10);
		return $urandom_range(20, 80);
	endfunction

	function automatic sample_t pick_sample(group_kind_t kind, sample_t base);
		int v;
		case (kind)
			GRP_WIDE: begin
				return sample_t'($urandom_range(0, 16'hffff));
			end
			GRP_NARROW: begin
				v = int'(base) + $urandom_range(0, 6) - 3;
				if (v > 32767) v = 32767;
				if (v < -32768) v = -32768;
				return sample_t'(v);
			end
			GRP_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return S_MIN;
					1: return S_MAX;
					2: return sample_t'(0);
					default: return sample_t'(-1);
				endcase
			end
			GRP_EQUAL: begin
				return base;
			end
			default: begin
				return ($urandom_range(0, 1) == 1) ? base : sample_t'($urandom_range(0, 16'hffff));
			end
		endcase
	endfunction

	task automatic send_sample(sample_t value, int unsigned gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= TDW'(value) & TDW'({W{1'b1}});
		do @(posedge clk); while (!s_tready);
		sb.note_request(value);
	endtask

	task automatic drain_pause();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
	endtask

	sample_t directed[25] = '{
		S_MAX, S_MIN, sample_t'(0), sample_t'(-1), sample_t'(1),
		S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
		S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
		sample_t'(5), sample_t'(5), sample_t'(5), sample_t'(-3), sample_t'(100),
		S_MAX, sample_t'(16384), sample_t'(-2), S_MIN, sample_t'(-16385)
	};

	initial begin
		group_kind_t kind;
		sample_t base;
		bit burst;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_sample(directed[i], next_gap(1'b0));
		drain_pause();

		for (int g = 0; g < RANDOM_GROUPS; g++) begin
			kind = group_kind_t'($urandom_range(0, 4));
			base = sample_t'($urandom_range(0, 16'hffff));
			burst = ($urandom_range(0, 3) == 0);
			if (g == 60 || $urandom_range(0, 99) < 3) begin
				drain_pause();
				for (int k = 0; k < N; k++) send_sample(pick_sample(kind, base), 0);
			end else begin
				for (int k = 0; k < N; k++) send_sample(pick_sample(kind, base), next_gap(burst));
			end
		end
		s_tvalid <= 1'b0;

		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() > 0) sb.errors++;
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: sim.f
design/tms_pkg.sv
design/tms_datapath.sv
design/tms_ctrl.sv
design/torben_median_select.sv
verif/tb_torben_median_select.sv
